/* hdl/ddwsr_pkg.sv */
// Shared types and constants for the differential-drive wheel speed ramp.
// No dependencies; imported by every module of the block.
package ddwsr_pkg;

  localparam int TRACK_W = 12;
  localparam int GAIN_W  = 24;
  localparam int STEP_W  = 16;
  localparam int TICK_W  = 16;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 2;
  localparam int SPEED_W = 16;
  localparam int MUL_W   = 24;
  localparam int PROD_W  = 2 * MUL_W;

  localparam logic [TRACK_W-1:0] TRACK_RST = 12'd400;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'd187760;
  localparam logic [STEP_W-1:0]  STEP_RST  = 16'd50;
  localparam logic [TICK_W-1:0]  TOUT_RST  = 16'd25;
  localparam logic [TICK_W-1:0]  TICK_MAX  = 16'hFFFF;

  localparam logic signed [15:0] LIN_LIMIT = 16'sd500;
  localparam logic signed [15:0] ANG_LIMIT = 16'sd300;
  localparam logic signed [22:0] BASE_SCALE = 23'sd2000;

  // gain product >> 20, then / 125: reciprocal 2^29/125 rounded up, exact below 2^22
  localparam int           GAIN_SHIFT = 20;
  localparam int           RECIP_SHIFT = 29;
  localparam logic [MUL_W-1:0] RECIP_125 = 24'd4294968;
  localparam logic [25:0]  SAT_LIMIT = 26'd4096000;  // 125 * 32768

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRACK = 2'd0,
    REG_GAIN  = 2'd1,
    REG_STEP  = 2'd2,
    REG_TOUT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [TRACK_W-1:0] track_width_mm;
    logic [GAIN_W-1:0]  rpm_gain_q16;
    logic [STEP_W-1:0]  accel_step;
    logic [TICK_W-1:0]  timeout_ticks;
  } cfg_t;

  typedef enum logic [2:0] {
    MS_TURN,
    MS_GAIN_L,
    MS_GAIN_R,
    MS_DIV_L,
    MS_DIV_R
  } mul_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TURN,
    ST_SUM,
    ST_MUL_L,
    ST_MUL_R,
    ST_DIV_L,
    ST_DIV_R,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sum_en;
    logic     capx_l;
    logic     capx_r;
    logic     capt_l;
    logic     commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage

/* hdl/diff_drive_wheel_speed_ramp_top.sv */
// Top level of the differential-drive wheel speed ramp.
// Depends on ddwsr_pkg, ddwsr_cfg, ddwsr_ctrl and ddwsr_dp.
//
// One input beat is one control tick: the velocity command is clamped, turned into
// left and right wheel targets in rpm, and the stored wheel commands are ramped toward
// them by at most accel_step (or forced to zero on timeout or emergency). A new tick is
// accepted only after the previous result is committed; the single 24x24 multiplier is
// used in turn for the turn term, both gain products and both divide-by-125 reciprocal
// products. The result sits in an output register, so a stalled consumer only holds the
// block once a second result is ready. Configuration writes take effect at once and
// belong between ticks.
module diff_drive_wheel_speed_ramp_top
  import ddwsr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        in_linear_mm_s,
  input  logic signed [15:0]        in_angular_mrad_s,
  input  logic                      in_new_command,
  input  logic                      in_emergency,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SPEED_W-1:0] out_left_cmd,
  output logic signed [SPEED_W-1:0] out_right_cmd,
  output logic                      out_stale
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  ddwsr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ddwsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ddwsr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (cmd),
    .status            (status),
    .in_linear_mm_s    (in_linear_mm_s),
    .in_angular_mrad_s (in_angular_mrad_s),
    .in_new_command    (in_new_command),
    .in_emergency      (in_emergency),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_left_cmd      (out_left_cmd),
    .out_right_cmd     (out_right_cmd),
    .out_stale         (out_stale)
  );

endmodule

/* hdl/ddwsr_cfg.sv */
// Configuration register file for the wheel speed ramp.
// Depends on ddwsr_pkg for the register map and reset values.
module ddwsr_cfg
  import ddwsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.track_width_mm <= TRACK_RST;
      cfg_r.rpm_gain_q16   <= GAIN_RST;
      cfg_r.accel_step     <= STEP_RST;
      cfg_r.timeout_ticks  <= TOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TRACK: cfg_r.track_width_mm <= cfg_wdata[TRACK_W-1:0];
        REG_GAIN:  cfg_r.rpm_gain_q16   <= cfg_wdata[GAIN_W-1:0];
        REG_STEP:  cfg_r.accel_step     <= cfg_wdata[STEP_W-1:0];
        REG_TOUT:  cfg_r.timeout_ticks  <= cfg_wdata[TICK_W-1:0];
        default:   ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/ddwsr_ctrl.sv */
// Sequencer for the wheel speed ramp: steps the shared multiplier schedule.
// Depends on ddwsr_pkg for state, command and status types.
module ddwsr_ctrl
  import ddwsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MS_TURN;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_TURN;
        end
      end
      ST_TURN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_TURN;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_MUL_L;
      end
      ST_MUL_L: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_GAIN_L;
        state_nxt   = ST_MUL_R;
      end
      ST_MUL_R: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_GAIN_R;
        cmd.capx_l  = 1'b1;
        state_nxt   = ST_DIV_L;
      end
      ST_DIV_L: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_DIV_L;
        cmd.capx_r  = 1'b1;
        state_nxt   = ST_DIV_R;
      end
      ST_DIV_R: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_DIV_R;
        cmd.capt_l  = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_full) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* hdl/ddwsr_dp.sv */
// Datapath for the wheel speed ramp: clamps, shared multiplier, ramp, output beat.
// Depends on ddwsr_pkg; driven by ddwsr_ctrl commands.
module ddwsr_dp
  import ddwsr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  input  logic signed [15:0]        in_linear_mm_s,
  input  logic signed [15:0]        in_angular_mrad_s,
  input  logic                      in_new_command,
  input  logic                      in_emergency,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SPEED_W-1:0] out_left_cmd,
  output logic signed [SPEED_W-1:0] out_right_cmd,
  output logic                      out_stale
);

  function automatic logic signed [SPEED_W-1:0] ramp_step(
    input logic signed [SPEED_W-1:0] cur,
    input logic signed [SPEED_W-1:0] tgt,
    input logic [STEP_W-1:0]         step
  );
    logic signed [17:0] c;
    logic signed [17:0] t;
    logic signed [17:0] s;
    logic signed [17:0] r;
    c = 18'(cur);
    t = 18'(tgt);
    s = $signed({2'b00, step});
    if (c < t) begin
      r = c + s;
      if (r > t) r = t;
    end else begin
      r = c - s;
      if (r < t) r = t;
    end
    return r[SPEED_W-1:0];
  endfunction

  function automatic logic signed [SPEED_W-1:0] to_target(
    input logic        neg,
    input logic        sat,
    input logic [14:0] q
  );
    logic signed [SPEED_W-1:0] v;
    v = $signed({1'b0, q});
    if (sat) return neg ? 16'sh8000 : 16'sh7FFF;
    return neg ? -v : v;
  endfunction

  logic signed [9:0]  lin_r;
  logic [8:0]         ang_mag_r;
  logic               ang_neg_r;
  logic               kill_r;
  logic               stale_r;
  logic [TICK_W-1:0]  ticks_r, ticks_nxt;

  logic [21:0]        mag_l_r, mag_r_r;
  logic               neg_l_r, neg_r_r;
  logic [21:0]        x_l_r, x_r_r;
  logic               sat_l_r, sat_r_r;
  logic signed [SPEED_W-1:0] tgt_l_r;
  logic [PROD_W-1:0]  prod_r;

  logic signed [SPEED_W-1:0] cur_l_r, cur_r_r;
  logic                      out_valid_r;
  logic signed [SPEED_W-1:0] out_left_r, out_right_r;
  logic                      out_stale_r;

  logic signed [9:0]  lin_c;
  logic signed [9:0]  ang_c;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic signed [22:0] base, turn_s, spd_l, spd_r, abs_l, abs_r;
  logic [25:0]        gprod;
  logic               gsat;
  logic [14:0]        quot;
  logic signed [SPEED_W-1:0] tgt_r, nxt_l, nxt_r;

  always_comb begin
    if (in_linear_mm_s > LIN_LIMIT)       lin_c = LIN_LIMIT[9:0];
    else if (in_linear_mm_s < -LIN_LIMIT) lin_c = 10'(-LIN_LIMIT);
    else                                  lin_c = in_linear_mm_s[9:0];
    if (in_angular_mrad_s > ANG_LIMIT)       ang_c = ANG_LIMIT[9:0];
    else if (in_angular_mrad_s < -ANG_LIMIT) ang_c = 10'(-ANG_LIMIT);
    else                                     ang_c = in_angular_mrad_s[9:0];
  end

  always_comb begin
    if (in_new_command)        ticks_nxt = '0;
    else if (ticks_r != TICK_MAX) ticks_nxt = ticks_r + 1'b1;
    else                       ticks_nxt = ticks_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TICK_MAX;
    end else if (cmd.load) begin
      ticks_r <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lin_r     <= lin_c;
      ang_neg_r <= ang_c[9];
      ang_mag_r <= ang_c[9] ? 9'(-ang_c) : ang_c[8:0];
      stale_r   <= (ticks_nxt > cfg.timeout_ticks);
      kill_r    <= (ticks_nxt > cfg.timeout_ticks) || in_emergency;
    end
  end

  // shared unsigned multiplier, one product per step
  always_comb begin
    unique case (cmd.mul_sel)
      MS_TURN: begin
        mul_a = MUL_W'(ang_mag_r);
        mul_b = MUL_W'(cfg.track_width_mm);
      end
      MS_GAIN_L: begin
        mul_a = MUL_W'(mag_l_r);
        mul_b = cfg.rpm_gain_q16;
      end
      MS_GAIN_R: begin
        mul_a = MUL_W'(mag_r_r);
        mul_b = cfg.rpm_gain_q16;
      end
      MS_DIV_L: begin
        mul_a = MUL_W'(x_l_r);
        mul_b = RECIP_125;
      end
      MS_DIV_R: begin
        mul_a = MUL_W'(x_r_r);
        mul_b = RECIP_125;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
  end

  always_comb begin
    base   = 23'(lin_r) * BASE_SCALE;
    turn_s = ang_neg_r ? -$signed({2'b00, prod_r[20:0]}) : $signed({2'b00, prod_r[20:0]});
    spd_l  = base - turn_s;
    spd_r  = base + turn_s;
    abs_l  = spd_l[22] ? -spd_l : spd_l;
    abs_r  = spd_r[22] ? -spd_r : spd_r;
    gprod  = prod_r[GAIN_SHIFT+25:GAIN_SHIFT];
    gsat   = (gprod >= SAT_LIMIT);
    quot   = prod_r[RECIP_SHIFT+14:RECIP_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      neg_l_r <= spd_l[22];
      neg_r_r <= spd_r[22];
      mag_l_r <= abs_l[21:0];
      mag_r_r <= abs_r[21:0];
    end
    if (cmd.capx_l) begin
      x_l_r   <= gprod[21:0];
      sat_l_r <= gsat;
    end
    if (cmd.capx_r) begin
      x_r_r   <= gprod[21:0];
      sat_r_r <= gsat;
    end
    if (cmd.capt_l) tgt_l_r <= to_target(neg_l_r, sat_l_r, quot);
  end

  always_comb begin
    tgt_r = to_target(neg_r_r, sat_r_r, quot);
    if (kill_r) begin
      nxt_l = '0;
      nxt_r = '0;
    end else begin
      nxt_l = ramp_step(cur_l_r, tgt_l_r, cfg.accel_step);
      nxt_r = ramp_step(cur_r_r, tgt_r, cfg.accel_step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_l_r     <= '0;
      cur_r_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        cur_l_r     <= nxt_l;
        cur_r_r     <= nxt_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_left_r  <= nxt_l;
      out_right_r <= nxt_r;
      out_stale_r <= stale_r;
    end
  end

  assign status.out_full = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_left_cmd    = out_left_r;
  assign out_right_cmd   = out_right_r;
  assign out_stale       = out_stale_r;

endmodule
